/* rtl/wfx_pkg.sv */
// Package for the wave effect engine: item and result types, request and
// effect codes, controller command and status structs. No dependencies.
package wfx_pkg;

  localparam int NUM_WAVES  = 32;
  localparam int WAVE_SIZE  = 128;
  localparam int WAVE_W     = $clog2(NUM_WAVES);
  localparam int SAMPLE_W   = $clog2(WAVE_SIZE);
  localparam int ADDR_W     = WAVE_W + SAMPLE_W;
  localparam int STORE_SIZE = NUM_WAVES * WAVE_SIZE;

  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_FX    = 2'd2;
  localparam logic [1:0] REQ_NONE  = 2'd3;

  localparam logic [3:0] FX_NONE      = 4'd0;
  localparam logic [3:0] FX_FILTER1   = 4'd1;
  localparam logic [3:0] FX_MIX       = 4'd2;
  localparam logic [3:0] FX_ROT_LEFT  = 4'd3;
  localparam logic [3:0] FX_ROT_RIGHT = 4'd4;
  localparam logic [3:0] FX_COMPRESS  = 4'd5;
  localparam logic [3:0] FX_STRETCH   = 4'd6;
  localparam logic [3:0] FX_NEGATE    = 4'd7;
  localparam logic [3:0] FX_MADMIX    = 4'd8;
  localparam logic [3:0] FX_ADD       = 4'd9;
  localparam logic [3:0] FX_FILTER2   = 4'd10;
  localparam logic [3:0] FX_MORPH     = 4'd11;
  localparam logic [3:0] FX_FASTMORPH = 4'd12;
  localparam logic [3:0] FX_FILTER3   = 4'd13;
  localparam logic [3:0] FX_POLYGATE  = 4'd14;
  localparam logic [3:0] FX_COLGATE   = 4'd15;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [11:0]       address;
    logic signed [7:0] write_data;
    logic [3:0]        effect_kind;
    logic [4:0]        dest_wave;
    logic [4:0]        source_a;
    logic [7:0]        source_b;
    logic [7:0]        wave_len;
    logic [6:0]        effect_step;
  } wfx_req_t;

  typedef struct packed {
    logic signed [7:0] read_data;
    logic [6:0]        next_step;
  } wfx_res_t;

  typedef struct packed {
    logic load;
    logic rd_a;
    logic rd_b;
    logic mul;
    logic wr;
  } wfx_cmd_t;

  typedef struct packed {
    logic empty;
    logic iter_last;
    logic pass_last;
  } wfx_stat_t;

endpackage

/* rtl/wfx_ctrl.sv */
// Controller state machine of the wave effect engine.
// Depends on wfx_pkg (command and status structs).
module wfx_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  wfx_pkg::wfx_stat_t stat_i,
  output wfx_pkg::wfx_cmd_t  cmd_o,
  output logic               busy_o,
  output logic               done_o
);
  import wfx_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SETUP = 7'b0000010,
    ST_RDA   = 7'b0000100,
    ST_RDB   = 7'b0001000,
    ST_MUL   = 7'b0010000,
    ST_WR    = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (start_i) state_d = ST_SETUP;
      ST_SETUP: state_d = stat_i.empty ? ST_DONE : ST_RDA;
      ST_RDA:   state_d = ST_RDB;
      ST_RDB:   state_d = ST_MUL;
      ST_MUL:   state_d = ST_WR;
      ST_WR:    state_d = (stat_i.iter_last && stat_i.pass_last) ? ST_DONE : ST_RDA;
      ST_DONE:  state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign cmd_o.load = (state_q == ST_IDLE) && start_i;
  assign cmd_o.rd_a = (state_q == ST_RDA);
  assign cmd_o.rd_b = (state_q == ST_RDB);
  assign cmd_o.mul  = (state_q == ST_MUL);
  assign cmd_o.wr   = (state_q == ST_WR);
  assign busy_o     = (state_q != ST_IDLE);
  assign done_o     = (state_q == ST_DONE);

endmodule

/* rtl/wfx_datapath.sv */
// Datapath of the wave effect engine: wave store, address generation,
// sample arithmetic and loop counters. Depends on wfx_pkg.
module wfx_datapath (
  input  logic               clk_i,
  input  wfx_pkg::wfx_req_t  req_i,
  input  wfx_pkg::wfx_cmd_t  cmd_i,
  output wfx_pkg::wfx_stat_t stat_o,
  output wfx_pkg::wfx_res_t  res_o
);
  import wfx_pkg::*;

  logic [7:0] mem_q [STORE_SIZE];
  logic [7:0] rdata_q;

  logic [1:0]          req_q;
  logic [ADDR_W-1:0]   addr_q;
  logic [7:0]          wdat_q;
  logic [3:0]          kind_q;
  logic [WAVE_W-1:0]   d_q, sa_q;
  logic [7:0]          sbraw_q, len_q;
  logic [6:0]          s_q, ns_q;
  logic                eq_q, pass_q;
  logic [7:0]          j_q;
  logic signed [7:0]   opa_q, save_q, acc_q, rd_out_q;
  logic signed [15:0]  pa_q, pb_q;

  // next phase and colgate match, from the raw item
  logic [7:0] len_c, s_inc;
  logic [6:0] ns_c;
  always_comb begin
    len_c = (req_i.wave_len > 8'd128) ? 8'd128 : req_i.wave_len;
    s_inc = {1'b0, req_i.effect_step} + 8'd1;
    ns_c  = req_i.effect_step;
    if (req_i.req_type == REQ_FX) begin
      case (req_i.effect_kind)
        FX_MIX, FX_MADMIX, FX_MORPH: ns_c = s_inc[6:0];
        FX_FASTMORPH:                ns_c = {2'b00, s_inc[4:0]};
        FX_NEGATE, FX_POLYGATE:      ns_c = (s_inc >= len_c) ? 7'd0 : s_inc[6:0];
        FX_COLGATE:                  ns_c = (s_inc == req_i.source_b) ? 7'd0 : s_inc[6:0];
        default:                     ns_c = req_i.effect_step;
      endcase
    end
  end

  // per-iteration addresses and coefficients
  logic [6:0]        j7, jj, pidx, mv, mw;
  logic [7:0]        pmask;
  logic [WAVE_W-1:0] sb;
  logic [7:0]        n;
  logic [ADDR_W-1:0] a_addr, b_addr, w_addr;
  logic signed [7:0] ka, kb;
  logic [2:0]        sh;
  logic              use_acc, last_save;

  always_comb begin
    j7    = j_q[6:0];
    jj    = ~j7;
    sb    = sbraw_q[WAVE_W-1:0];
    pmask = ({1'b0, s_q} + sbraw_q) & (len_q - 8'd1);
    pidx  = pmask[6:0];
    mv    = 7'd0;
    mw    = 7'd0;
    if (kind_q == FX_MORPH) begin
      mv = (ns_q >= 7'd64) ? (7'd127 - ns_q) : ns_q;
      mw = 7'd63 - mv;
    end else begin
      mv = (ns_q >= 7'd16) ? (7'd31 - ns_q) : ns_q;
      mw = 7'd15 - mv;
    end
    n         = 8'd0;
    a_addr    = {d_q, j7};
    b_addr    = {d_q, j7};
    w_addr    = {d_q, j7};
    ka        = 8'sd0;
    kb        = 8'sd1;
    sh        = 3'd0;
    use_acc   = 1'b0;
    last_save = 1'b0;
    case (req_q)
      REQ_WRITE: begin
        n      = 8'd1;
        w_addr = addr_q;
      end
      REQ_READ: begin
        n      = 8'd1;
        a_addr = addr_q;
      end
      REQ_FX: begin
        case (kind_q)
          FX_FILTER1, FX_COLGATE: begin
            if (kind_q == FX_COLGATE && pass_q) begin
              n      = 8'd128;
              b_addr = {d_q, j7[6] ? {1'b0, j7[5:0]} : {j7[5:0], 1'b0}};
            end else begin
              n      = 8'd127;
              b_addr = {d_q, j7 + 7'd1};
              ka     = 8'sd1;
              sh     = 3'd1;
            end
          end
          FX_FILTER2, FX_FILTER3: begin
            n      = 8'd126;
            b_addr = {d_q, j7 + 7'd2};
            w_addr = {d_q, j7 + 7'd1};
            ka     = (kind_q == FX_FILTER2) ? 8'sd3 : 8'sd1;
            sh     = (kind_q == FX_FILTER2) ? 3'd2 : 3'd1;
          end
          FX_MIX: begin
            n      = len_q;
            a_addr = {sa_q, j7};
            b_addr = {sb, s_q + j7};
            ka     = 8'sd1;
            sh     = 3'd1;
          end
          FX_ROT_LEFT: begin
            n         = 8'd128;
            b_addr    = {d_q, j7 + 7'd1};
            last_save = 1'b1;
          end
          FX_ROT_RIGHT: begin
            n         = 8'd128;
            a_addr    = {d_q, jj};
            b_addr    = {d_q, jj - 7'd1};
            w_addr    = {d_q, jj};
            last_save = 1'b1;
          end
          FX_COMPRESS: begin
            n      = 8'd128;
            b_addr = {d_q, j7[6] ? {1'b0, j7[5:0]} : {j7[5:0], 1'b0}};
          end
          FX_STRETCH: begin
            n      = 8'd128;
            b_addr = {d_q, 7'd63 - {1'b0, j7[6:1]}};
            w_addr = {d_q, jj};
          end
          FX_NEGATE, FX_POLYGATE: begin
            n      = (kind_q == FX_NEGATE) ? 8'd1 : 8'd2;
            a_addr = {d_q, j7[0] ? pidx : s_q};
            w_addr = a_addr;
            ka     = -8'sd1;
            kb     = 8'sd0;
          end
          FX_MADMIX: begin
            n       = len_q;
            a_addr  = {sb, ns_q};
            use_acc = 1'b1;
          end
          FX_ADD: begin
            n      = len_q;
            a_addr = {sb, j7};
            ka     = 8'sd1;
          end
          FX_MORPH, FX_FASTMORPH: begin
            n      = len_q;
            a_addr = {sa_q, j7};
            b_addr = {sb, j7};
            ka     = $signed({1'b0, mv});
            kb     = $signed({1'b0, mw});
            sh     = (kind_q == FX_MORPH) ? 3'd6 : 3'd4;
          end
          default: n = 8'd0;
        endcase
      end
      default: n = 8'd0;
    endcase
  end

  assign stat_o.empty     = (n == 8'd0);
  assign stat_o.iter_last = (j_q == n - 8'd1);
  assign stat_o.pass_last = !(req_q == REQ_FX && kind_q == FX_COLGATE && eq_q && !pass_q);

  // write value
  logic signed [17:0] sum;
  logic signed [17:0] shifted;
  logic [7:0]         wval;
  logic               do_wr;
  always_comb begin
    sum     = 18'(pa_q) + 18'(pb_q) + (use_acc ? 18'(acc_q) : 18'sd0);
    shifted = sum >>> sh;
    wval    = shifted[7:0];
    if (req_q == REQ_WRITE) begin
      wval = wdat_q;
    end else if (last_save && j_q == 8'd127) begin
      wval = save_q;
    end
    do_wr = cmd_i.wr && (req_q == REQ_WRITE || req_q == REQ_FX);
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[w_addr] <= wval;
    end
    if (cmd_i.rd_a || cmd_i.rd_b) begin
      rdata_q <= mem_q[cmd_i.rd_b ? b_addr : a_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q    <= req_i.req_type;
      addr_q   <= req_i.address;
      wdat_q   <= req_i.write_data;
      kind_q   <= req_i.effect_kind;
      d_q      <= req_i.dest_wave;
      sa_q     <= req_i.source_a;
      sbraw_q  <= req_i.source_b;
      len_q    <= len_c;
      s_q      <= req_i.effect_step;
      ns_q     <= ns_c;
      eq_q     <= (s_inc == req_i.source_b);
      pass_q   <= 1'b0;
      j_q      <= 8'd0;
      acc_q    <= 8'sd3;
      rd_out_q <= 8'sd0;
    end
    if (cmd_i.rd_b) begin
      opa_q <= rdata_q;
      if (j_q == 8'd0) begin
        save_q <= rdata_q;
      end
    end
    if (cmd_i.mul) begin
      pa_q <= opa_q * ka;
      pb_q <= $signed(rdata_q) * kb;
    end
    if (cmd_i.wr) begin
      acc_q <= acc_q + save_q;
      if (req_q == REQ_READ) begin
        rd_out_q <= opa_q;
      end
      if (stat_o.iter_last) begin
        j_q    <= 8'd0;
        pass_q <= 1'b1;
      end else begin
        j_q <= j_q + 8'd1;
      end
    end
  end

  assign res_o.read_data = rd_out_q;
  assign res_o.next_step = ns_q;

endmodule

/* rtl/wavetable_effect_engine.sv */
// Wave effect engine: 32 waves of 128 signed samples, byte access and effects.
// Each request runs a setup step, then for each sample two reads, a multiply and a
// write, set by the single store port; a new request is accepted only in idle,
// after done_o.
// Reset clears the controller only; the wave store is undefined until written.
// Results are strobed on done_o for one cycle; the receiver cannot stall.
module wavetable_effect_engine (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  wfx_pkg::wfx_req_t req_i,
  output logic              busy_o,
  output logic              done_o,
  output wfx_pkg::wfx_res_t res_o
);
  import wfx_pkg::*;

  wfx_cmd_t  cmd;
  wfx_stat_t stat;

  // sequencer: setup, then read A, read B, multiply, write per sample
  wfx_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy_o),
    .done_o  (done_o)
  );

  // store, address generation and sample arithmetic
  wfx_datapath u_dp (
    .clk_i  (clk_i),
    .req_i  (req_i),
    .cmd_i  (cmd),
    .stat_o (stat),
    .res_o  (res_o)
  );

endmodule
